/* design/hrls_pkg.sv */
// ----------------------------------------------------------------------------
// hrls_pkg
// Types, constants and per-byte helpers of the request line splitter.
// ----------------------------------------------------------------------------
package hrls_pkg;

	localparam int MAX_LINE  = 2048;
	localparam int EXT_CHARS = 4;
	localparam int LINE_W    = $clog2(MAX_LINE + 1);
	localparam int EXT_W     = EXT_CHARS * 8;
	localparam int EXTLEN_W  = $clog2(EXT_CHARS + 2);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] KIND_METHOD  = 2'd0;
	localparam logic [1:0] KIND_PATH    = 2'd1;
	localparam logic [1:0] KIND_VERSION = 2'd2;
	localparam logic [1:0] KIND_DROP    = 2'd3;

	localparam logic [2:0] MIME_HTML  = 3'd0;
	localparam logic [2:0] MIME_JPEG  = 3'd1;
	localparam logic [2:0] MIME_CSS   = 3'd2;
	localparam logic [2:0] MIME_JS    = 3'd3;
	localparam logic [2:0] MIME_OTHER = 3'd4;

	localparam logic [31:0] EXT_HTML = 32'h68746d6c;
	localparam logic [31:0] EXT_JPEG = 32'h6a706567;
	localparam logic [23:0] EXT_JPG  = 24'h6a7067;
	localparam logic [23:0] EXT_CSS  = 24'h637373;
	localparam logic [15:0] EXT_JS   = 16'h6a73;

	typedef struct packed {
		logic [1:0]          space_cnt;
		logic [15:0]         prev;
		logic                esc;
		logic                line_fin;
		logic                cr_held;
		logic [EXT_W-1:0]    ext_chars;
		logic [EXTLEN_W-1:0] ext_len;
		logic                dot_seg;
		logic [LINE_W-1:0]   line_len;
	} st_t;

	typedef struct packed {
		st_t        st;
		logic [1:0] kind;
	} lb_ret_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       line_end;
		logic       path_ok;
		logic [2:0] mime;
		logic       req_end;
	} res_t;

	function automatic logic [2:0] classify(input st_t s);
		logic [2:0] c;
		c = MIME_OTHER;
		if (s.dot_seg) begin
			if (s.ext_len == EXTLEN_W'(4) && s.ext_chars == EXT_W'(EXT_HTML))
				c = MIME_HTML;
			else if (s.ext_len == EXTLEN_W'(3) && s.ext_chars == EXT_W'(EXT_JPG))
				c = MIME_JPEG;
			else if (s.ext_len == EXTLEN_W'(4) && s.ext_chars == EXT_W'(EXT_JPEG))
				c = MIME_JPEG;
			else if (s.ext_len == EXTLEN_W'(3) && s.ext_chars == EXT_W'(EXT_CSS))
				c = MIME_CSS;
			else if (s.ext_len == EXTLEN_W'(2) && s.ext_chars == EXT_W'(EXT_JS))
				c = MIME_JS;
		end
		return c;
	endfunction

	function automatic st_t track_path(input st_t s, input logic [7:0] b);
		st_t t;
		t = s;
		if (b == CH_SLASH) begin
			t.dot_seg   = 1'b0;
			t.ext_len   = '0;
			t.ext_chars = '0;
		end else if (b == CH_DOT) begin
			t.dot_seg   = 1'b1;
			t.ext_len   = '0;
			t.ext_chars = '0;
		end else if (s.dot_seg && s.ext_len <= EXTLEN_W'(EXT_CHARS)) begin
			if (s.ext_len < EXTLEN_W'(EXT_CHARS)) begin
				t.ext_chars = {s.ext_chars[EXT_W-9:0], b};
				t.ext_len   = s.ext_len + EXTLEN_W'(1);
			end else begin
				t.ext_len = EXTLEN_W'(EXT_CHARS + 1);
			end
		end
		return t;
	endfunction

	// one byte inside the request line
	function automatic lb_ret_t line_byte(input st_t s, input logic [7:0] b);
		lb_ret_t r;
		r.st   = s;
		r.kind = KIND_DROP;
		if (s.line_len < LINE_W'(MAX_LINE)) begin
			r.st.line_len = s.line_len + LINE_W'(1);
			r.st.prev     = {s.prev[7:0], b};
			if (!s.esc) begin
				if (b == CH_DOT && s.prev[7:0] == CH_DOT && s.prev[15:8] == CH_SLASH) begin
					r.st.esc = 1'b1;
				end else if (b == CH_SPACE) begin
					if (s.space_cnt != 2'd3)
						r.st.space_cnt = s.space_cnt + 2'd1;
				end else begin
					r.kind = s.space_cnt;
					if (s.space_cnt == KIND_PATH)
						r.st = track_path(r.st, b);
				end
			end
		end
		return r;
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
			input logic le, input st_t s);
		res_t r;
		r.kind     = kind;
		r.data     = b;
		r.line_end = le;
		r.path_ok  = le & ~s.esc;
		r.mime     = le ? classify(s) : MIME_HTML;
		r.req_end  = 1'b0;
		return r;
	endfunction

endpackage

/* design/http_request_line_splitter.sv */
// path: input stage, then the result register that drives m_*
// throughput: one item per cycle unless m_tready stalls; an item with two
//   results (a released cr plus the byte) holds the input on the pending slot
// reset: arst_n clears all line state and empties the input and output stages
// ----------------------------------------------------------------------------
// http_request_line_splitter
// Tags request line bytes as method, path or version, checks the path for a
// dot-dot escape and classifies the file extension at the end of the line.
// ----------------------------------------------------------------------------
module http_request_line_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [8] line_end, [9] path_ok,
	                               // [12:10] mime_class, [15:13] zero
	output logic [1:0]  m_tuser,   // field_kind
	output logic        m_tlast    // request_end
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	hrls_pkg::st_t      st_q;
	hrls_pkg::st_t      st_d;
	hrls_pkg::res_t     out_q;
	hrls_pkg::res_t     pend_q;
	logic               out_valid_q;
	logic               pend_valid_q;
	hrls_pkg::res_t     r0;
	hrls_pkg::res_t     r1;
	logic               n0;
	logic               n1;
	logic               out_free;
	logic               consume;

	assign out_free = !out_valid_q || m_tready;
	assign consume  = valid_s1 && out_free && !pend_valid_q;
	assign s_tready = !valid_s1 || consume;

	always_comb begin
		hrls_pkg::st_t    s;
		hrls_pkg::lb_ret_t lr;
		hrls_pkg::res_t   x;
		s  = st_q;
		r0 = '0;
		r1 = '0;
		n0 = 1'b0;
		n1 = 1'b0;
		x  = '0;
		lr = '0;
		if (s.line_fin) begin
			r0 = hrls_pkg::mk_res(hrls_pkg::KIND_DROP, byte_s1, 1'b0, s);
			n0 = 1'b1;
		end else if (s.cr_held && byte_s1 == hrls_pkg::CH_LF) begin
			s.cr_held  = 1'b0;
			s.line_fin = 1'b1;
			r0 = hrls_pkg::mk_res(hrls_pkg::KIND_DROP, byte_s1, 1'b1, s);
			n0 = 1'b1;
		end else begin
			if (s.cr_held) begin
				s.cr_held = 1'b0;
				lr = hrls_pkg::line_byte(s, hrls_pkg::CH_CR);
				s  = lr.st;
				r0 = hrls_pkg::mk_res(lr.kind, hrls_pkg::CH_CR, 1'b0, s);
				n0 = 1'b1;
			end
			if (byte_s1 == hrls_pkg::CH_CR && !last_s1) begin
				s.cr_held = 1'b1;
			end else begin
				lr = hrls_pkg::line_byte(s, byte_s1);
				s  = lr.st;
				if (last_s1)
					s.line_fin = 1'b1;
				x = hrls_pkg::mk_res(lr.kind, byte_s1, last_s1, s);
				if (n0) begin
					r1 = x;
					n1 = 1'b1;
				end else begin
					r0 = x;
					n0 = 1'b1;
				end
			end
		end
		if (last_s1) begin
			if (n1)
				r1.req_end = 1'b1;
			else
				r0.req_end = 1'b1;
			st_d = '0;
		end else begin
			st_d = s;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (consume) begin
			st_q <= st_d;
		end
	end

	// result register and pending slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (consume && n0) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= n1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (consume) begin
				out_q  <= r0;
				pend_q <= r1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.mime, out_q.path_ok, out_q.line_end, out_q.data};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.req_end;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without a result in the output register");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> (st_q.line_len == '0 && !st_q.cr_held && !st_q.line_fin))
		else $error("line state not cleared after last byte");

	a_cr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cr_held |-> !st_q.line_fin)
		else $error("cr held after the line finished");

	a_space_counted: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.space_cnt != 2'd0 |-> st_q.line_len != '0)
		else $error("space counted with no line byte taken");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the request line splitter. A directed table walks
// the byte extremes, dot-dot escapes, held and released carriage returns,
// spaces past the version and a one-byte request. Random requests follow,
// mostly well-formed lines with random paths and extensions, mixed with
// truncated requests, noise and one overlong line. Each result item is
// checked against its directed table row or a behavioral tagger kept in
// the bench, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [7:0]     b;
		logic           last;
		logic           typed;
		hrls_pkg::res_t want;
	} dir_row_t;

	localparam int N_DIR = 23;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [7:0] data_byte, [8] line_end, [9] path_ok,
	                        // [12:10] mime_class, [15:13] zero
	logic [1:0]  m_tuser;   // field_kind
	logic        m_tlast;

	// tagger state
	logic [1:0]  spaces_seen = '0;
	logic [15:0] last_two = '0;
	logic        dotdot_found = 1'b0;
	logic        line_done = 1'b0;
	logic        cr_pending = 1'b0;
	logic [31:0] ext_buf = '0;
	logic [2:0]  ext_cnt = '0;
	logic        ext_open = 1'b0;
	int          line_cnt = 0;

	hrls_pkg::res_t step_items[$];
	hrls_pkg::res_t tagged_due[$];
	logic [7:0]  req_bytes[$];
	int          errors = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	int          long_len = 0;
	logic [31:0] rx_cycle = '0;

	dir_row_t dir_rows [0:N_DIR-1] = '{
		'{8'h47, 1'b0, 1'b1,
			'{hrls_pkg::KIND_METHOD, 8'h47, 1'b0, 1'b0, hrls_pkg::MIME_HTML, 1'b0}},
		'{8'h00, 1'b0, 1'b1,
			'{hrls_pkg::KIND_METHOD, 8'h00, 1'b0, 1'b0, hrls_pkg::MIME_HTML, 1'b0}},
		'{8'hFF, 1'b0, 1'b1,
			'{hrls_pkg::KIND_METHOD, 8'hFF, 1'b0, 1'b0, hrls_pkg::MIME_HTML, 1'b0}},
		'{hrls_pkg::CH_SPACE, 1'b0, 1'b1,
			'{hrls_pkg::KIND_DROP, hrls_pkg::CH_SPACE, 1'b0, 1'b0, hrls_pkg::MIME_HTML, 1'b0}},
		'{hrls_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_DOT, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_DOT, 1'b0, 1'b1,
			'{hrls_pkg::KIND_DROP, hrls_pkg::CH_DOT, 1'b0, 1'b0, hrls_pkg::MIME_HTML, 1'b0}},
		'{8'h78, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_CR, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_LF, 1'b1, 1'b1,
			'{hrls_pkg::KIND_DROP, hrls_pkg::CH_LF, 1'b1, 1'b0, hrls_pkg::MIME_OTHER, 1'b1}},
		// escape right behind the space
		'{hrls_pkg::CH_SPACE, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_SLASH, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_DOT, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_DOT, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_CR, 1'b0, 1'b0, '0},
		'{8'h61, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_CR, 1'b1, 1'b0, '0},
		// three spaces, then bytes past the version
		'{hrls_pkg::CH_SPACE, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_SPACE, 1'b0, 1'b0, '0},
		'{hrls_pkg::CH_SPACE, 1'b0, 1'b0, '0},
		'{8'h56, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b0, '0},
		'{8'h78, 1'b1, 1'b1,
			'{hrls_pkg::KIND_METHOD, 8'h78, 1'b1, 1'b1, hrls_pkg::MIME_OTHER, 1'b1}}
	};

	http_request_line_splitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void add_result(input logic [1:0] k, input logic [7:0] b,
			input logic le);
		hrls_pkg::res_t r;
		logic [2:0] m;
		m = hrls_pkg::MIME_OTHER;
		if (ext_open) begin
			if (ext_cnt == 3'd4 && ext_buf == hrls_pkg::EXT_HTML)
				m = hrls_pkg::MIME_HTML;
			else if (ext_cnt == 3'd3 && ext_buf == 32'(hrls_pkg::EXT_JPG))
				m = hrls_pkg::MIME_JPEG;
			else if (ext_cnt == 3'd4 && ext_buf == hrls_pkg::EXT_JPEG)
				m = hrls_pkg::MIME_JPEG;
			else if (ext_cnt == 3'd3 && ext_buf == 32'(hrls_pkg::EXT_CSS))
				m = hrls_pkg::MIME_CSS;
			else if (ext_cnt == 3'd2 && ext_buf == 32'(hrls_pkg::EXT_JS))
				m = hrls_pkg::MIME_JS;
		end
		r.kind     = k;
		r.data     = b;
		r.line_end = le;
		r.path_ok  = le & ~dotdot_found;
		r.mime     = le ? m : hrls_pkg::MIME_HTML;
		r.req_end  = 1'b0;
		step_items.push_back(r);
	endfunction

	function automatic logic [1:0] tag_line_byte(input logic [7:0] b);
		logic [7:0] p1;
		logic [7:0] p2;
		logic [1:0] k;
		k = hrls_pkg::KIND_DROP;
		if (line_cnt < hrls_pkg::MAX_LINE) begin
			line_cnt++;
			p1 = last_two[7:0];
			p2 = last_two[15:8];
			last_two = {last_two[7:0], b};
			if (dotdot_found) begin
				k = hrls_pkg::KIND_DROP;
			end else if (b == hrls_pkg::CH_DOT && p1 == hrls_pkg::CH_DOT &&
					p2 == hrls_pkg::CH_SLASH) begin
				dotdot_found = 1'b1;
			end else if (b == hrls_pkg::CH_SPACE) begin
				if (spaces_seen != 2'd3)
					spaces_seen++;
			end else begin
				k = spaces_seen;
				if (spaces_seen == hrls_pkg::KIND_PATH) begin
					if (b == hrls_pkg::CH_SLASH || b == hrls_pkg::CH_DOT) begin
						ext_open = (b == hrls_pkg::CH_DOT);
						ext_cnt  = '0;
						ext_buf  = '0;
					end else if (ext_open && ext_cnt < 3'(hrls_pkg::EXT_CHARS)) begin
						ext_buf = {ext_buf[23:0], b};
						ext_cnt++;
					end else if (ext_open) begin
						ext_cnt = 3'(hrls_pkg::EXT_CHARS + 1);
					end
				end
			end
		end
		return k;
	endfunction

	// works out the result items one input byte causes
	function automatic void tag_request_byte(input logic [7:0] b, input logic last);
		hrls_pkg::res_t r;
		step_items.delete();
		if (line_done) begin
			add_result(hrls_pkg::KIND_DROP, b, 1'b0);
		end else if (cr_pending && b == hrls_pkg::CH_LF) begin
			cr_pending = 1'b0;
			line_done  = 1'b1;
			add_result(hrls_pkg::KIND_DROP, b, 1'b1);
		end else begin
			if (cr_pending) begin
				cr_pending = 1'b0;
				add_result(tag_line_byte(hrls_pkg::CH_CR), hrls_pkg::CH_CR, 1'b0);
			end
			if (b == hrls_pkg::CH_CR && !last) begin
				cr_pending = 1'b1;
			end else begin
				r.kind = tag_line_byte(b);
				if (last)
					line_done = 1'b1;
				add_result(r.kind, b, last);
			end
		end
		if (last) begin
			r = step_items.pop_back();
			r.req_end = 1'b1;
			step_items.push_back(r);
			spaces_seen  = '0;
			last_two     = '0;
			dotdot_found = 1'b0;
			line_done    = 1'b0;
			cr_pending   = 1'b0;
			ext_buf      = '0;
			ext_cnt      = '0;
			ext_open     = 1'b0;
			line_cnt     = 0;
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
			input hrls_pkg::res_t want);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		tag_request_byte(b, last);
		if (typed)
			tagged_due.push_back(want);
		else
			foreach (step_items[i]) tagged_due.push_back(step_items[i]);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) :
				$urandom_range(0, 15);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(0, 4))
				@(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tagged_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] name_char();
		string pool;
		pool = "abcdefghijklmnopqrstuvwxyzABCZ0129-_";
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	task automatic build_request();
		string methods [0:4] = '{"GET", "HEAD", "POST", "PUT", "X"};
		string exts [0:11] = '{"html", "jpg", "jpeg", "css", "js", "htm", "htmls",
			"JPG", "c", "", "jpe", "jss"};
		string near;
		int keep;
		near = "jscsshtmlpeg";
		req_bytes.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 10)) begin
				case ($urandom_range(0, 8))
					0: req_bytes.push_back(hrls_pkg::CH_CR);
					1: req_bytes.push_back(hrls_pkg::CH_LF);
					2: req_bytes.push_back(hrls_pkg::CH_SLASH);
					3: req_bytes.push_back(hrls_pkg::CH_DOT);
					4: req_bytes.push_back(hrls_pkg::CH_SPACE);
					default: req_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			return;
		end
		add_text(methods[$urandom_range(0, 4)]);
		if ($urandom_range(0, 9) == 0)
			add_text("  ");
		else
			add_text(" ");
		repeat ($urandom_range(1, 3)) begin
			req_bytes.push_back(hrls_pkg::CH_SLASH);
			if ($urandom_range(0, 9) == 0)
				add_text("..");
			repeat ($urandom_range(0, 4)) req_bytes.push_back(name_char());
			if ($urandom_range(0, 7) == 0)
				req_bytes.push_back(hrls_pkg::CH_CR);
			if ($urandom_range(0, 9) == 0)
				req_bytes.push_back(hrls_pkg::CH_DOT);
		end
		if ($urandom_range(0, 3) != 0) begin
			req_bytes.push_back(hrls_pkg::CH_DOT);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6))
					req_bytes.push_back(near[$urandom_range(0, near.len() - 1)]);
			else
				add_text(exts[$urandom_range(0, 11)]);
		end
		if ($urandom_range(0, 9) != 0)
			add_text(" HTTP/1.1");
		if ($urandom_range(0, 9) == 0)
			add_text(" x");
		case ($urandom_range(0, 9))
			0: ;
			1: begin
				req_bytes.push_back(hrls_pkg::CH_CR);
				req_bytes.push_back(hrls_pkg::CH_CR);
				req_bytes.push_back(hrls_pkg::CH_LF);
			end
			2: req_bytes.push_back(hrls_pkg::CH_LF);
			default: begin
				req_bytes.push_back(hrls_pkg::CH_CR);
				req_bytes.push_back(hrls_pkg::CH_LF);
			end
		endcase
		repeat ($urandom_range(0, 2)) begin
			add_text("Host: a");
			req_bytes.push_back(hrls_pkg::CH_CR);
			req_bytes.push_back(hrls_pkg::CH_LF);
		end
		if ($urandom_range(0, 7) == 0) begin
			keep = $urandom_range(1, req_bytes.size());
			while (req_bytes.size() > keep) void'(req_bytes.pop_back());
		end
	endtask

	task automatic send_request();
		for (int i = 0; i < req_bytes.size(); i++)
			send_item(req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0);
	endtask

	// receiver stall patterns, chosen by bits [8:6] of the cycle counter
	always @(negedge clk) begin
		rx_cycle = rx_cycle + 1;
		case (rx_cycle[8:6])
			3'd0, 3'd1: m_tready <= 1'b1;
			3'd2, 3'd3: m_tready <= $urandom_range(0, 3) != 0;
			3'd4: m_tready <= (rx_cycle % 5) < 3;
			3'd5: m_tready <= rx_cycle[3:0] > 4'd6;
			3'd6: m_tready <= $urandom_range(0, 1);
			default: m_tready <= rx_cycle[2:0] != 3'd0;
		endcase
	end

	always @(posedge clk) begin
		hrls_pkg::res_t got;
		hrls_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[12:10], m_tlast};
			if (tagged_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item kind=%0d data=%h line_end=%b request_end=%b",
					$time, got.kind, got.data, got.line_end, got.req_end);
			end else begin
				want = tagged_due.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.line_end !== want.line_end || got.path_ok !== want.path_ok ||
						got.mime !== want.mime || got.req_end !== want.req_end ||
						m_tdata[15:13] !== 3'b000) begin
					errors++;
					$display("%0t: expected kind=%0d data=%h line_end=%b path_ok=%b mime=%0d %s",
						$time, want.kind, want.data, want.line_end, want.path_ok, want.mime,
						$sformatf("request_end=%b pad=0", want.req_end));
					$display("%0t: actual   kind=%0d data=%h line_end=%b path_ok=%b mime=%0d %s",
						$time, got.kind, got.data, got.line_end, got.path_ok, got.mime,
						$sformatf("request_end=%b pad=%0d", got.req_end, m_tdata[15:13]));
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
		drain_results();
		for (int n = 0; bytes_sent < N_DIR + 500 + long_len; n++) begin
			build_request();
			send_request();
			if (n % 16 == 15)
				drain_results();
			if (n == 4) begin
				req_bytes.delete();
				add_text("GET /");
				repeat ($urandom_range(2038, 2046)) req_bytes.push_back(8'h61);
				add_text(".html HTTP/1.1");
				req_bytes.push_back(hrls_pkg::CH_CR);
				req_bytes.push_back(hrls_pkg::CH_LF);
				long_len = req_bytes.size();
				send_request();
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tagged_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
